// ===== sv/acbd_pkg.sv =====
package acbd_pkg;

  // Add-with-carry opcodes, one per addressing mode.
  localparam logic [7:0] OP_IMM           = 8'h69;
  localparam logic [7:0] OP_ABS           = 8'h6D;
  localparam logic [7:0] OP_ABS_LONG      = 8'h6F;
  localparam logic [7:0] OP_DP            = 8'h65;
  localparam logic [7:0] OP_DP_IND        = 8'h72;
  localparam logic [7:0] OP_DP_IND_LONG   = 8'h67;
  localparam logic [7:0] OP_ABS_X         = 8'h7D;
  localparam logic [7:0] OP_ABS_LONG_X    = 8'h7F;
  localparam logic [7:0] OP_ABS_Y         = 8'h79;
  localparam logic [7:0] OP_DP_X          = 8'h75;
  localparam logic [7:0] OP_DP_X_IND      = 8'h61;
  localparam logic [7:0] OP_DP_IND_Y      = 8'h71;
  localparam logic [7:0] OP_DP_IND_LONG_Y = 8'h77;
  localparam logic [7:0] OP_SR            = 8'h63;
  localparam logic [7:0] OP_SR_IND_Y      = 8'h73;

  // Configuration register map.
  localparam logic [1:0] REG_EXTRA_DEC_ADDR = 2'd0;

  // Packed BCD digit limits.
  localparam logic [4:0] BCD_MAX_DIGIT = 5'd9;
  localparam logic [3:0] BCD_ADJUST    = 4'd6;

  // One instruction as it enters the unit.
  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] accumulator;
    logic [15:0] operand;
    logic        carry_in;
    logic        wide;
    logic        decimal;
    logic        dp_low_nonzero;
    logic        page_cross;
  } acbd_in_t;

  // Timing figures from the opcode decode.
  typedef struct packed {
    logic [2:0] pc_advance;
    logic [3:0] cycle_count;
    logic       opcode_known;
  } acbd_timing_t;

  // After the low byte has been added.
  typedef struct packed {
    logic [7:0]   acc_hi;
    logic [7:0]   opd_hi;
    logic [7:0]   bin_lo;
    logic         bin_c8;
    logic [7:0]   bcd_lo;
    logic         bcd_c8;
    logic         acc_b7;
    logic         opd_b7;
    logic         wide;
    logic         decimal;
    acbd_timing_t timing;
  } acbd_s1_t;

  // After the full sum has been formed.
  typedef struct packed {
    logic [15:0]  sum;
    logic [7:0]   acc_hi;
    logic         carry;
    logic         overflow;
    logic         wide;
    logic         decimal;
    acbd_timing_t timing;
  } acbd_s2_t;

  // Final result item.
  typedef struct packed {
    logic [15:0]  result;
    logic         carry_out;
    logic         overflow_out;
    logic         overflow_written;
    logic         negative;
    logic         zero;
    acbd_timing_t timing;
  } acbd_out_t;

  // One BCD digit add: returns {carry, digit}. A sum above nine gets the
  // decimal adjust and the digit keeps the low four bits.
  function automatic logic [4:0] bcd_digit(input logic [3:0] a, input logic [3:0] b,
                                           input logic c);
    logic [4:0] d;
    d = {1'b0, a} + {1'b0, b} + {4'b0000, c};
    if (d > BCD_MAX_DIGIT) begin
      bcd_digit = {1'b1, d[3:0] + BCD_ADJUST};
    end else begin
      bcd_digit = {1'b0, d[3:0]};
    end
  endfunction

endpackage

// ===== sv/add_with_carry_binary_decimal_alu.sv =====
// Channel   Direction  Signals                       Contents
// s_axis    in         tvalid tready tdata tuser     one add-with-carry instruction
// m_axis    out        tvalid tready tdata           new accumulator, flags, timing
// apb       in/out     psel penable pwrite paddr...  extra_decimal_cycle at address 0
//
// Every instruction passes one register stage each for low byte, high byte and
// flags between input transfer and a valid result; a new instruction can be
// taken in every cycle unless a stalled output has filled the pipeline. Reset
// clears the stage valid bits and the configuration register. When the output
// stalls, each stage holds its item and the ready signals fall back stage by stage only as the pipeline fills.
module add_with_carry_binary_decimal_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input instruction stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] opcode, [23:8] accumulator, [39:24] operand, [40] carry_in,
  // [41] dp_low_nonzero, [42] page_cross, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  // [0] wide, [1] decimal
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] result, [16] carry_out, [17] overflow_out, [18] overflow_written,
  // [19] negative, [20] zero, [23:21] pc_advance, [27:24] cycle_count,
  // [28] opcode_known, [31:29] zero
  output logic [31:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import acbd_pkg::*;

  logic      extra_dec_q;
  logic      extra_dec_d;
  acbd_in_t  in_item;
  logic      s1_valid;
  logic      s1_ready;
  acbd_s1_t  s1_data;
  logic      s2_valid;
  logic      s2_ready;
  acbd_s2_t  s2_data;
  acbd_out_t out_item;

  // Configuration register.
  assign pready = 1'b1;

  always_comb begin
    extra_dec_d = extra_dec_q;
    if (psel && penable && pwrite && (paddr == REG_EXTRA_DEC_ADDR)) begin
      extra_dec_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_dec_q <= 1'b0;
    end else begin
      extra_dec_q <= extra_dec_d;
    end
  end

  assign prdata = {31'b0, (paddr == REG_EXTRA_DEC_ADDR) & extra_dec_q};

  // Unpack the input transfer.
  always_comb begin
    in_item.opcode         = s_axis_tdata[7:0];
    in_item.accumulator    = s_axis_tdata[23:8];
    in_item.operand        = s_axis_tdata[39:24];
    in_item.carry_in       = s_axis_tdata[40];
    in_item.dp_low_nonzero = s_axis_tdata[41];
    in_item.page_cross     = s_axis_tdata[42];
    in_item.wide           = s_axis_tuser[0];
    in_item.decimal        = s_axis_tuser[1];
  end

  acbd_lo_stage u_lo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .data_i      (in_item),
    .extra_dec_i (extra_dec_q),
    .valid_o     (s1_valid),
    .ready_i     (s1_ready),
    .data_o      (s1_data)
  );

  acbd_hi_stage u_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  acbd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_item)
  );

  // Pack the result transfer.
  assign m_axis_tdata = {3'b000,
                         out_item.timing.opcode_known,
                         out_item.timing.cycle_count,
                         out_item.timing.pc_advance,
                         out_item.zero,
                         out_item.negative,
                         out_item.overflow_written,
                         out_item.overflow_out,
                         out_item.carry_out,
                         out_item.result};

endmodule

// ===== sv/acbd_decode.sv =====
module acbd_decode (
  input  logic [7:0]            opcode_i,
  input  logic                  wide_i,
  input  logic                  decimal_i,
  input  logic                  dp_low_nonzero_i,
  input  logic                  page_cross_i,
  input  logic                  extra_dec_i,
  output acbd_pkg::acbd_timing_t timing_o
);
  import acbd_pkg::*;

  logic [2:0] pc;
  logic [3:0] base;
  logic       known;
  logic       dp;
  logic       pcx;

  assign dp  = dp_low_nonzero_i;
  assign pcx = page_cross_i;

  // Addressing mode table: length and base cycle count.
  always_comb begin
    pc    = 3'd0;
    base  = 4'd0;
    known = 1'b1;
    unique case (opcode_i)
      OP_IMM: begin
        pc = 3'd2 + {2'b00, wide_i}; base = 4'd2;
      end
      OP_ABS:           begin pc = 3'd3; base = 4'd4; end
      OP_ABS_LONG:      begin pc = 3'd4; base = 4'd5; end
      OP_DP:            begin pc = 3'd2; base = 4'd3 + {3'b000, dp}; end
      OP_DP_IND:        begin pc = 3'd2; base = 4'd5 + {3'b000, dp}; end
      OP_DP_IND_LONG:   begin pc = 3'd2; base = 4'd6 + {3'b000, dp}; end
      OP_ABS_X:         begin pc = 3'd3; base = 4'd4 + {3'b000, pcx}; end
      OP_ABS_LONG_X:    begin pc = 3'd4; base = 4'd5; end
      OP_ABS_Y:         begin pc = 3'd3; base = 4'd4 + {3'b000, pcx}; end
      OP_DP_X:          begin pc = 3'd2; base = 4'd4 + {3'b000, dp}; end
      OP_DP_X_IND:      begin pc = 3'd2; base = 4'd6 + {3'b000, dp}; end
      OP_DP_IND_Y: begin
        pc = 3'd2; base = 4'd5 + {3'b000, dp} + {3'b000, pcx};
      end
      OP_DP_IND_LONG_Y: begin pc = 3'd2; base = 4'd6 + {3'b000, dp}; end
      OP_SR:            begin pc = 3'd2; base = 4'd4; end
      OP_SR_IND_Y:      begin pc = 3'd2; base = 4'd7; end
      default:          begin known = 1'b0; end
    endcase
  end

  // Width and decimal penalties apply only to known encodings.
  always_comb begin
    timing_o.opcode_known = known;
    timing_o.pc_advance   = pc;
    if (known) begin
      timing_o.cycle_count = base + {3'b000, wide_i} + {3'b000, decimal_i & extra_dec_i};
    end else begin
      timing_o.cycle_count = 4'd0;
    end
  end

endmodule

// ===== sv/acbd_lo_stage.sv =====
module acbd_lo_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  acbd_pkg::acbd_in_t data_i,
  input  logic               extra_dec_i,
  output logic               valid_o,
  input  logic               ready_i,
  output acbd_pkg::acbd_s1_t data_o
);
  import acbd_pkg::*;

  logic         valid_q;
  acbd_s1_t     data_d;
  acbd_s1_t     data_q;
  acbd_timing_t timing;
  logic [8:0]   bin_lo;
  logic [4:0]   dig0;
  logic [4:0]   dig1;

  acbd_decode u_decode (
    .opcode_i         (data_i.opcode),
    .wide_i           (data_i.wide),
    .decimal_i        (data_i.decimal),
    .dp_low_nonzero_i (data_i.dp_low_nonzero),
    .page_cross_i     (data_i.page_cross),
    .extra_dec_i      (extra_dec_i),
    .timing_o         (timing)
  );

  // Low byte, both as binary and as two BCD digits.
  always_comb begin
    bin_lo = {1'b0, data_i.accumulator[7:0]} + {1'b0, data_i.operand[7:0]}
           + {8'h00, data_i.carry_in};
    dig0   = bcd_digit(data_i.accumulator[3:0], data_i.operand[3:0], data_i.carry_in);
    dig1   = bcd_digit(data_i.accumulator[7:4], data_i.operand[7:4], dig0[4]);

    data_d.acc_hi  = data_i.accumulator[15:8];
    data_d.opd_hi  = data_i.operand[15:8];
    data_d.bin_lo  = bin_lo[7:0];
    data_d.bin_c8  = bin_lo[8];
    data_d.bcd_lo  = {dig1[3:0], dig0[3:0]};
    data_d.bcd_c8  = dig1[4];
    data_d.acc_b7  = data_i.accumulator[7];
    data_d.opd_b7  = data_i.operand[7];
    data_d.wide    = data_i.wide;
    data_d.decimal = data_i.decimal;
    data_d.timing  = timing;
  end

  // The stage takes a new item when empty or when its content moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/acbd_hi_stage.sv =====
module acbd_hi_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  acbd_pkg::acbd_s1_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output acbd_pkg::acbd_s2_t data_o
);
  import acbd_pkg::*;

  logic       valid_q;
  acbd_s2_t   data_d;
  acbd_s2_t   data_q;
  logic [8:0] bin_hi;
  logic [4:0] dig2;
  logic [4:0] dig3;
  logic [15:0] sum;
  logic        sign_a;
  logic        sign_b;
  logic        sign_s;

  // High byte, then selection by mode and width.
  always_comb begin
    bin_hi = {1'b0, data_i.acc_hi} + {1'b0, data_i.opd_hi} + {8'h00, data_i.bin_c8};
    dig2   = bcd_digit(data_i.acc_hi[3:0], data_i.opd_hi[3:0], data_i.bcd_c8);
    dig3   = bcd_digit(data_i.acc_hi[7:4], data_i.opd_hi[7:4], dig2[4]);

    if (data_i.decimal) begin
      sum          = data_i.wide ? {dig3[3:0], dig2[3:0], data_i.bcd_lo}
                                 : {8'h00, data_i.bcd_lo};
      data_d.carry = data_i.wide ? dig3[4] : data_i.bcd_c8;
    end else begin
      sum          = data_i.wide ? {bin_hi[7:0], data_i.bin_lo} : {8'h00, data_i.bin_lo};
      data_d.carry = data_i.wide ? bin_hi[8] : data_i.bin_c8;
    end

    // Signed overflow, binary mode only: equal operand signs and a sum of the other sign.
    sign_a = data_i.wide ? data_i.acc_hi[7] : data_i.acc_b7;
    sign_b = data_i.wide ? data_i.opd_hi[7] : data_i.opd_b7;
    sign_s = data_i.wide ? sum[15] : sum[7];

    data_d.sum      = sum;
    data_d.acc_hi   = data_i.acc_hi;
    data_d.overflow = !data_i.decimal && (sign_a == sign_b) && (sign_a != sign_s);
    data_d.wide     = data_i.wide;
    data_d.decimal  = data_i.decimal;
    data_d.timing   = data_i.timing;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/acbd_out_stage.sv =====
module acbd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  acbd_pkg::acbd_s2_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output acbd_pkg::acbd_out_t data_o
);
  import acbd_pkg::*;

  logic      valid_q;
  acbd_out_t data_d;
  acbd_out_t data_q;

  // Flags at the active width; the 8-bit form keeps the upper accumulator byte.
  always_comb begin
    data_d.result           = data_i.wide ? data_i.sum : {data_i.acc_hi, data_i.sum[7:0]};
    data_d.carry_out        = data_i.carry;
    data_d.overflow_out     = data_i.overflow;
    data_d.overflow_written = !data_i.decimal;
    data_d.negative         = data_i.wide ? data_i.sum[15] : data_i.sum[7];
    data_d.zero             = (data_i.sum == 16'h0000);
    data_d.timing           = data_i.timing;
  end

  // This register is the output register of the unit.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/acbd_checker.sv =====
module acbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result transfer keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With the output draining, the pipeline never pushes back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked although output is ready");

  // An accepted instruction reaches the output through the low, high and output stages while the output stays ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after three cycles");

  // Reset empties the pipeline.
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind add_with_carry_binary_decimal_alu acbd_checker u_acbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/acbd_result_monitor.sv =====
`timescale 1ns / 1ps

// Watches the instruction, result and configuration channels, predicts each
// add-with-carry result and compares it with what the unit delivers.
module acbd_result_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [7:0] opcode, [23:8] accumulator, [39:24] operand, [40] carry_in,
  // [41] dp_low_nonzero, [42] page_cross, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  // [0] wide, [1] decimal
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] result, [16] carry_out, [17] overflow_out, [18] overflow_written,
  // [19] negative, [20] zero, [23:21] pc_advance, [27:24] cycle_count,
  // [28] opcode_known, [31:29] zero
  input  logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          error_count_o,
  output int          pending_results_o
);
  import acbd_pkg::*;

  acbd_out_t expected_sums[$];
  logic      extra_dec_cycle;

  // Predict one add-with-carry instruction under the given register setting.
  function automatic acbd_out_t predict_adc(input acbd_in_t instr, input logic extra_dec);
    logic [15:0] mask;
    logic [15:0] sign_bit;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] sum;
    logic [16:0] full;
    logic [4:0]  digit;
    logic        carry;
    logic        ovf;
    logic [2:0]  pc;
    logic [3:0]  cyc;
    logic        known;
    acbd_out_t   res;
    int          i;
    mask     = instr.wide ? 16'hFFFF : 16'h00FF;
    sign_bit = instr.wide ? 16'h8000 : 16'h0080;
    a        = instr.accumulator & mask;
    b        = instr.operand & mask;
    sum      = '0;
    ovf      = 1'b0;
    if (instr.decimal) begin
      // Packed BCD, one nibble at a time; a digit sum above nine is adjusted.
      carry = instr.carry_in;
      for (i = 0; i < (instr.wide ? 4 : 2); i++) begin
        digit = {1'b0, a[4*i +: 4]} + {1'b0, b[4*i +: 4]} + {4'b0000, carry};
        if (digit > 5'd9) begin
          digit = digit + 5'd6;
          carry = 1'b1;
        end else begin
          carry = 1'b0;
        end
        sum[4*i +: 4] = digit[3:0];
      end
    end else begin
      full  = {1'b0, a} + {1'b0, b} + {16'h0000, instr.carry_in};
      sum   = full[15:0] & mask;
      carry = instr.wide ? full[16] : full[8];
      ovf   = |(~(a ^ b) & (a ^ sum) & sign_bit);
    end

    // Addressing mode decides the program counter advance and base cycles.
    known = 1'b1;
    pc    = '0;
    cyc   = '0;
    case (instr.opcode)
      OP_IMM: begin
        pc  = 3'd2 + {2'b00, instr.wide};
        cyc = 4'd2;
      end
      OP_ABS: begin
        pc  = 3'd3;
        cyc = 4'd4;
      end
      OP_ABS_LONG: begin
        pc  = 3'd4;
        cyc = 4'd5;
      end
      OP_DP: begin
        pc  = 3'd2;
        cyc = 4'd3 + {3'b000, instr.dp_low_nonzero};
      end
      OP_DP_IND: begin
        pc  = 3'd2;
        cyc = 4'd5 + {3'b000, instr.dp_low_nonzero};
      end
      OP_DP_IND_LONG: begin
        pc  = 3'd2;
        cyc = 4'd6 + {3'b000, instr.dp_low_nonzero};
      end
      OP_ABS_X: begin
        pc  = 3'd3;
        cyc = 4'd4 + {3'b000, instr.page_cross};
      end
      OP_ABS_LONG_X: begin
        pc  = 3'd4;
        cyc = 4'd5;
      end
      OP_ABS_Y: begin
        pc  = 3'd3;
        cyc = 4'd4 + {3'b000, instr.page_cross};
      end
      OP_DP_X: begin
        pc  = 3'd2;
        cyc = 4'd4 + {3'b000, instr.dp_low_nonzero};
      end
      OP_DP_X_IND: begin
        pc  = 3'd2;
        cyc = 4'd6 + {3'b000, instr.dp_low_nonzero};
      end
      OP_DP_IND_Y: begin
        pc  = 3'd2;
        cyc = 4'd5 + {3'b000, instr.dp_low_nonzero} + {3'b000, instr.page_cross};
      end
      OP_DP_IND_LONG_Y: begin
        pc  = 3'd2;
        cyc = 4'd6 + {3'b000, instr.dp_low_nonzero};
      end
      OP_SR: begin
        pc  = 3'd2;
        cyc = 4'd4;
      end
      OP_SR_IND_Y: begin
        pc  = 3'd2;
        cyc = 4'd7;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    if (known) begin
      cyc = cyc + {3'b000, instr.wide} + {3'b000, instr.decimal & extra_dec};
    end

    res.result                  = instr.wide ? sum : {instr.accumulator[15:8], sum[7:0]};
    res.carry_out               = carry;
    res.overflow_out            = ovf;
    res.overflow_written        = ~instr.decimal;
    res.negative                = |(sum & sign_bit);
    res.zero                    = (sum == 16'h0000);
    res.timing.pc_advance       = pc;
    res.timing.cycle_count      = cyc;
    res.timing.opcode_known     = known;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
      error_count_o++;
    end
  endtask

  // Track the register, queue a prediction per input transfer and compare
  // each result transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    acbd_in_t  instr;
    acbd_out_t exp;
    if (!rst_ni) begin
      extra_dec_cycle   = 1'b0;
      error_count_o     = 0;
      expected_sums.delete();
      pending_results_o = 0;
    end else begin
      if (psel && penable && pready && paddr == REG_EXTRA_DEC_ADDR) begin
        if (pwrite) begin
          extra_dec_cycle = pwdata[0];
        end else begin
          check_field("prdata", {31'd0, extra_dec_cycle}, prdata);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        instr.opcode         = s_axis_tdata[7:0];
        instr.accumulator    = s_axis_tdata[23:8];
        instr.operand        = s_axis_tdata[39:24];
        instr.carry_in       = s_axis_tdata[40];
        instr.dp_low_nonzero = s_axis_tdata[41];
        instr.page_cross     = s_axis_tdata[42];
        instr.wide           = s_axis_tuser[0];
        instr.decimal        = s_axis_tuser[1];
        expected_sums.push_back(predict_adc(instr, extra_dec_cycle));
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          $error("result transfer %0h with no instruction outstanding", m_axis_tdata);
          error_count_o++;
        end else begin
          exp = expected_sums.pop_front();
          check_field("result", 32'(exp.result), 32'(m_axis_tdata[15:0]));
          check_field("carry_out", 32'(exp.carry_out), 32'(m_axis_tdata[16]));
          check_field("overflow_out", 32'(exp.overflow_out), 32'(m_axis_tdata[17]));
          check_field("overflow_written", 32'(exp.overflow_written),
                      32'(m_axis_tdata[18]));
          check_field("negative", 32'(exp.negative), 32'(m_axis_tdata[19]));
          check_field("zero", 32'(exp.zero), 32'(m_axis_tdata[20]));
          check_field("pc_advance", 32'(exp.timing.pc_advance), 32'(m_axis_tdata[23:21]));
          check_field("cycle_count", 32'(exp.timing.cycle_count),
                      32'(m_axis_tdata[27:24]));
          check_field("opcode_known", 32'(exp.timing.opcode_known), 32'(m_axis_tdata[28]));
        end
      end
      pending_results_o = expected_sums.size();
    end
  end

endmodule

// ===== tb/sv/tb_add_with_carry_binary_decimal_alu.sv =====
`timescale 1ns / 1ps

module tb_add_with_carry_binary_decimal_alu;
  import acbd_pkg::*;

  localparam int PHASE_ITEMS = 370;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 3000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] opcode, [23:8] accumulator, [39:24] operand, [40] carry_in,
  // [41] dp_low_nonzero, [42] page_cross, [47:43] zero
  logic [47:0] s_axis_tdata  = '0;
  // [0] wide, [1] decimal
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] result, [16] carry_out, [17] overflow_out, [18] overflow_written,
  // [19] negative, [20] zero, [23:21] pc_advance, [27:24] cycle_count,
  // [28] opcode_known, [31:29] zero
  logic [31:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [1:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int pending_results;
  int stall_cycles   = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  bit quiet          = 1'b0;

  add_with_carry_binary_decimal_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  acbd_result_monitor monitor (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .error_count_o     (error_count),
    .pending_results_o (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up when no transfer has happened on either stream for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: random backpressure, or a long hold when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_served++;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 26);
      end
    end
  end

  function automatic logic [7:0] adc_opcode(input int idx);
    case (idx)
      0:       return OP_IMM;
      1:       return OP_ABS;
      2:       return OP_ABS_LONG;
      3:       return OP_DP;
      4:       return OP_DP_IND;
      5:       return OP_DP_IND_LONG;
      6:       return OP_ABS_X;
      7:       return OP_ABS_LONG_X;
      8:       return OP_ABS_Y;
      9:       return OP_DP_X;
      10:      return OP_DP_X_IND;
      11:      return OP_DP_IND_Y;
      12:      return OP_DP_IND_LONG_Y;
      13:      return OP_SR;
      default: return OP_SR_IND_Y;
    endcase
  endfunction

  function automatic acbd_in_t make_instr(input logic [7:0] op, input logic [15:0] acc,
                                          input logic [15:0] opd, input logic [4:0] flags);
    acbd_in_t instr;
    instr.opcode         = op;
    instr.accumulator    = acc;
    instr.operand        = opd;
    instr.carry_in       = flags[0];
    instr.wide           = flags[1];
    instr.decimal        = flags[2];
    instr.dp_low_nonzero = flags[3];
    instr.page_cross     = flags[4];
    return instr;
  endfunction

  // Mostly real add encodings; decimal ones usually carry valid BCD digits.
  function automatic acbd_in_t random_instr();
    acbd_in_t instr;
    int       i;
    instr = make_instr(8'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
    if ($urandom_range(99) < 80) begin
      instr.opcode = adc_opcode($urandom_range(14));
    end
    if (instr.decimal && $urandom_range(99) < 60) begin
      for (i = 0; i < 4; i++) begin
        instr.accumulator[4*i +: 4] = 4'($urandom_range(9));
        instr.operand[4*i +: 4]     = 4'($urandom_range(9));
      end
    end
    return instr;
  endfunction

  // Offer one instruction after a random gap and wait for its transfer.
  task automatic send_instr(input acbd_in_t instr);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < 26) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b00000, instr.page_cross, instr.dp_low_nonzero, instr.carry_in,
                      instr.operand, instr.accumulator, instr.opcode};
    s_axis_tuser  <= {instr.decimal, instr.wide};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted result has arrived.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_EXTRA_DEC_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the extra decimal cycle setting and read it back.
  task automatic set_extra_decimal(input logic value);
    apb_access(1'b1, {31'($urandom), value});
    apb_access(1'b0, 32'd0);
  endtask

  initial begin
    int k;
    int phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_extra_decimal(1'b0);

    // Every addressing mode once, walking the flag combinations.
    for (k = 0; k < 15; k++) begin
      send_instr(make_instr(adc_opcode(k), 16'h0F0F ^ (16'h1111 * k[15:0]),
                            16'h3C5A + 16'h0123 * k[15:0], k[4:0]));
    end
    // Width extremes, signed overflow, BCD carry, invalid digits and unknown opcodes.
    send_instr(make_instr(OP_ABS, 16'hFFFF, 16'hFFFF, 5'b00011));
    send_instr(make_instr(OP_IMM, 16'hAB00, 16'hFF00, 5'b00000));
    send_instr(make_instr(OP_DP, 16'h127F, 16'h0001, 5'b01000));
    send_instr(make_instr(OP_ABS_X, 16'h7FFF, 16'h0001, 5'b10010));
    send_instr(make_instr(OP_ABS_Y, 16'h8000, 16'h8000, 5'b10010));
    send_instr(make_instr(OP_IMM, 16'h5599, 16'h0001, 5'b00100));
    send_instr(make_instr(OP_IMM, 16'h9999, 16'h0000, 5'b00111));
    send_instr(make_instr(OP_DP_IND_Y, 16'hFFFF, 16'hFFFF, 5'b11111));
    send_instr(make_instr(8'h00, 16'h1234, 16'h4321, 5'b00000));
    send_instr(make_instr(8'hFF, 16'h0909, 16'h0101, 5'b00110));

    // Random phases: setting alternates; one with a long output hold,
    // one with no idling on either side.
    for (phase = 0; phase < 5; phase++) begin
      drain_results();
      set_extra_decimal(~phase[0]);
      quiet = (phase == 2);
      if (phase == 1) begin
        hold_requests++;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_instr(random_instr());
      end
    end
    drain_results();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
